/* rtl/clsa_pkg.sv */
package clsa_pkg;

  // Widths fixed by the request and result fields.
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 10;

  // Default number of record slots in the ring.
  localparam int RECORD_SLOTS_DEFAULT = 1024;

  // Request command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch the request and read the oldest and newest records
    logic exec;  // apply the request and register its result
  } ctrl_cmd_t;

endpackage

/* rtl/clsa_ctrl.sv */
module clsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output clsa_pkg::ctrl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // A request is taken while idle; the following cycle applies it.
  assign busy     = (state == ST_EXEC);
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == ST_EXEC);

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = cmd.load ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
    endcase
  end

  // State register and result strobe, which follows the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

endmodule

/* rtl/clsa_datapath.sv */
module clsa_datapath #(
  parameter int RECORD_SLOTS = clsa_pkg::RECORD_SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  clsa_pkg::ctrl_cmd_t               cmd,
  input  logic                              command,
  input  logic [clsa_pkg::DATA_W-1:0]       request_length,
  input  logic                              cfg_we,
  input  logic [clsa_pkg::DATA_W-1:0]       cfg_data,
  output logic                              ok,
  output logic [clsa_pkg::DATA_W-1:0]       start_address,
  output logic [clsa_pkg::DATA_W-1:0]       record_length,
  output logic                              overflowed,
  output logic [clsa_pkg::COUNT_W-1:0]      record_count
);

  localparam int DW     = clsa_pkg::DATA_W;
  localparam int SlotW  = $clog2(RECORD_SLOTS);
  localparam int HeldW  = (SlotW > clsa_pkg::COUNT_W) ? SlotW : clsa_pkg::COUNT_W;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RECORD_SLOTS - 1);
  localparam logic [SlotW:0]   SlotsExt = (SlotW + 1)'(RECORD_SLOTS);

  // Record storage: start address and length of each record.
  logic [DW-1:0] start_mem  [RECORD_SLOTS];
  logic [DW-1:0] length_mem [RECORD_SLOTS];

  logic [SlotW-1:0] write_slot, write_slot_next;
  logic [SlotW-1:0] read_slot, read_slot_next;
  logic             overflow_flag, overflow_flag_next;
  logic [DW-1:0]    space_limit;

  // Latched request and the records read for it.
  logic          cmd_q;
  logic [DW-1:0] len_q;
  logic [DW-1:0] old_start, old_len, new_start, new_len;

  logic          ok_q;
  logic [DW-1:0] start_q, len_out_q;

  logic [SlotW-1:0] held, newest_slot, write_inc, read_inc;
  logic             ring_full;

  logic [DW:0]   single_sum;
  logic [DW:0]   newest_end;
  logic [DW+1:0] end_plus_len;

  logic             mem_we;
  logic [SlotW-1:0] mem_addr;
  logic [DW-1:0]    mem_start;
  logic             res_ok;
  logic [DW-1:0]    res_start, res_len;
  logic             do_append, do_replace, do_drop;
  logic [DW-1:0]    append_start;

  // Records held, with the ring size not necessarily a power of two.
  always_comb begin
    if (write_slot >= read_slot) begin
      held = write_slot - read_slot;
    end else begin
      held = SlotW'({1'b0, write_slot} + SlotsExt - {1'b0, read_slot});
    end
  end

  assign ring_full   = (held == LastSlot);
  assign newest_slot = (write_slot == '0) ? LastSlot : write_slot - 1'b1;
  assign write_inc   = (write_slot == LastSlot) ? '0 : write_slot + 1'b1;
  assign read_inc    = (read_slot == LastSlot) ? '0 : read_slot + 1'b1;

  // Full-precision sums for the space checks.
  assign single_sum   = {1'b0, old_len} + {1'b0, len_q};
  assign newest_end   = {1'b0, new_start} + {1'b0, new_len};
  assign end_plus_len = {1'b0, newest_end} + {2'b00, len_q};

  // Placement decision for a push.
  always_comb begin
    do_append    = 1'b0;
    do_replace   = 1'b0;
    do_drop      = 1'b0;
    append_start = '0;
    priority if (held == '0) begin
      do_append = 1'b1;
    end else if (held == SlotW'(1)) begin
      if (single_sum > {1'b0, space_limit}) begin
        do_replace = 1'b1;
      end else begin
        do_append    = 1'b1;
        append_start = old_start + old_len;
      end
    end else if (ring_full) begin
      do_drop = 1'b1;
    end else if (new_start > old_start) begin
      if (end_plus_len <= {2'b00, space_limit}) begin
        do_append    = 1'b1;
        append_start = newest_end[DW-1:0];
      end else if (len_q <= old_start) begin
        do_append = 1'b1;
      end else begin
        do_drop = 1'b1;
      end
    end else if (end_plus_len <= {2'b00, old_start}) begin
      do_append    = 1'b1;
      append_start = newest_end[DW-1:0];
    end else begin
      do_drop = 1'b1;
    end
  end

  // Next state and result of the latched request.
  always_comb begin
    mem_we             = 1'b0;
    mem_addr           = write_slot;
    mem_start          = append_start;
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    overflow_flag_next = overflow_flag;
    res_ok             = 1'b0;
    res_start          = '0;
    res_len            = '0;
    if (cmd_q == clsa_pkg::CMD_PUSH) begin
      res_len = len_q;
      if (do_append) begin
        mem_we          = 1'b1;
        write_slot_next = write_inc;
        res_ok          = 1'b1;
        res_start       = append_start;
      end
      if (do_replace) begin
        mem_we             = 1'b1;
        mem_addr           = read_slot;
        mem_start          = '0;
        overflow_flag_next = 1'b1;
        res_ok             = 1'b1;
      end
      if (do_drop) begin
        read_slot_next     = read_inc;
        overflow_flag_next = 1'b1;
      end
    end else if (held != '0) begin
      read_slot_next     = read_inc;
      overflow_flag_next = 1'b0;
      res_ok             = 1'b1;
      res_start          = old_start;
      res_len            = old_len;
    end
  end

  // Control registers and the space limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      read_slot     <= '0;
      overflow_flag <= 1'b0;
      space_limit   <= '0;
    end else begin
      if (cfg_we) begin
        space_limit <= cfg_data;
      end
      if (cmd.exec) begin
        write_slot    <= write_slot_next;
        read_slot     <= read_slot_next;
        overflow_flag <= overflow_flag_next;
      end
    end
  end

  // Request latch and registered reads of the oldest and newest records.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q     <= command;
      len_q     <= request_length;
      old_start <= start_mem[read_slot];
      old_len   <= length_mem[read_slot];
      new_start <= start_mem[newest_slot];
      new_len   <= length_mem[newest_slot];
    end
  end

  // Record store write.
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      start_mem[mem_addr]  <= mem_start;
      length_mem[mem_addr] <= len_q;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_q      <= res_ok;
      start_q   <= res_start;
      len_out_q <= res_len;
    end
  end

  assign ok            = ok_q;
  assign start_address = start_q;
  assign record_length = len_out_q;
  assign overflowed    = overflow_flag;
  assign record_count  = clsa_pkg::COUNT_W'(HeldW'(held));

endmodule

/* rtl/circular_log_space_allocator.sv */
// Circular log space allocator: a ring of (start, length) records laid out in a
// circular storage space whose size is the space limit register.
// Request channel: command and request_length are taken at a rising edge where
// start is high and busy is low. A push appends after the newest record, wraps
// to address zero, replaces a lone record or fails; a pop returns the oldest record.
// Configuration channel: cfg_data is written to the space limit at an edge where
// cfg_valid and cfg_ready are both high; write it only while no request is open.
// Result: done is high for exactly one cycle once the request has left the
// execute state, with ok, start_address, record_length, overflowed and record_count.
// The receiver cannot hold a result off, so none is ever stalled.
// A new request is not taken while one executes. The load cycle reads the oldest and
// newest records from the record store, the execute cycle decides and writes at most
// one record back; busy is high during the execute cycle only.
// Reset clears the slot pointers, the overflow flag and the space limit; the
// record store itself is not cleared, as only records in occupied slots are used.
module circular_log_space_allocator #(
  parameter int RECORD_SLOTS = clsa_pkg::RECORD_SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [clsa_pkg::DATA_W-1:0]       request_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clsa_pkg::DATA_W-1:0]       cfg_data,
  output logic                              done,
  output logic                              ok,
  output logic [clsa_pkg::DATA_W-1:0]       start_address,
  output logic [clsa_pkg::DATA_W-1:0]       record_length,
  output logic                              overflowed,
  output logic [clsa_pkg::COUNT_W-1:0]      record_count
);

  clsa_pkg::ctrl_cmd_t cmd;

  // Configuration writes are taken between requests.
  assign cfg_ready = !busy;

  clsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  clsa_datapath #(
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .command        (command),
    .request_length (request_length),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .ok             (ok),
    .start_address  (start_address),
    .record_length  (record_length),
    .overflowed     (overflowed),
    .record_count   (record_count)
  );

`ifndef ASSERT_OFF
  // A result only ever follows the execute cycle of a request.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in execution");

  // A taken request always enters execution in the next cycle.
  a_start_to_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("taken request did not enter execution");

  // A failed request never reports a start address.
  a_fail_zero_start: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (start_address == '0))
    else $error("failed request reported a start address");
`endif

endmodule

/* sim/circular_log_space_allocator_test.sv */
module circular_log_space_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W  = clsa_pkg::DATA_W;
  localparam int COUNT_W = clsa_pkg::COUNT_W;
  localparam int SLOTS   = clsa_pkg::RECORD_SLOTS_DEFAULT;

  // One result of the allocator, field for field as it leaves the ports.
  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  start_address;
    logic [DATA_W-1:0]  record_length;
    logic               overflowed;
    logic [COUNT_W-1:0] record_count;
  } allocation_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // A directed row is either a request or a write of the space limit.
  // A row holds its own expected result only where typed is set.
  typedef struct packed {
    row_kind_t          kind;
    logic               cmd;
    logic [DATA_W-1:0]  value;
    logic               typed;
    allocation_result_t expected;
  } directed_row_t;

  localparam allocation_result_t UNTYPED = '0;

  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // Space limit is zero after reset.
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'h0000_0000, 1'b1,
      '{1'b0, 32'h0, 32'h0, 1'b0, 10'd0}},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h0, 32'h0, 1'b0, 10'd1}},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h0, 32'h0, 1'b0, 10'd2}},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0005, 1'b1,
      '{1'b0, 32'h0, 32'h5, 1'b1, 10'd1}},
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'hFFFF_FFFF, 1'b1,
      '{1'b1, 32'h0, 32'h0, 1'b0, 10'd0}},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0, 10'd1}},
    // Single record that cannot be followed: replaced at zero.
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0001, 1'b1,
      '{1'b1, 32'h0, 32'h1, 1'b1, 10'd1}},
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'h0000_0000, 1'b1,
      '{1'b1, 32'h0, 32'h1, 1'b0, 10'd0}},
    '{ROW_CFG, clsa_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h8000_0000, 1'b1,
      '{1'b1, 32'h0, 32'h8000_0000, 1'b0, 10'd1}},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h7FFF_FFFF, 1'b1,
      '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 10'd2}},
    // The end of the space sums to exactly 2**32: it must not wrap.
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0001, 1'b1,
      '{1'b0, 32'h0, 32'h1, 1'b1, 10'd1}},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0010, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 32'h10, 1'b1, 10'd2}},
    // Wrap to zero, then an append in the wrapped layout.
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0010, 1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h0000_0020, 1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'h8000_0000, 1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'h0000_0000, 1'b0, UNTYPED},
    '{ROW_CFG, clsa_pkg::CMD_PUSH, 32'd100,       1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'd60,        1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'd30,        1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'd20,        1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_POP,  32'd0,         1'b0, UNTYPED},
    '{ROW_REQ, clsa_pkg::CMD_PUSH, 32'd40,        1'b0, UNTYPED}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               command = clsa_pkg::CMD_PUSH;
  logic [DATA_W-1:0]  request_length = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DATA_W-1:0]  cfg_data = '0;
  logic               done;
  logic               ok;
  logic [DATA_W-1:0]  start_address;
  logic [DATA_W-1:0]  record_length;
  logic               overflowed;
  logic [COUNT_W-1:0] record_count;

  // Own copy of the ring, the overflow flag and the space limit.
  logic [DATA_W-1:0]  extent_start [SLOTS];
  logic [DATA_W-1:0]  extent_len [SLOTS];
  int unsigned        wr_slot = 0;
  int unsigned        rd_slot = 0;
  logic               ovf_flag = 1'b0;
  logic [DATA_W-1:0]  space_limit_q = '0;

  allocation_result_t pending_results [$];

  int mismatches = 0;
  int results_seen = 0;
  int rand_items = 0;
  int placed_pushes = 0;
  int refused_pushes = 0;
  int returned_pops = 0;
  int empty_pops = 0;
  int cfg_writes = 0;
  int peak_records = 0;

  circular_log_space_allocator i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .request_length (request_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .ok             (ok),
    .start_address  (start_address),
    .record_length  (record_length),
    .overflowed     (overflowed),
    .record_count   (record_count)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("circular_log_space_allocator regression: fail");
    $finish;
  end

  function automatic int unsigned held_records();
    return (wr_slot + SLOTS - rd_slot) % SLOTS;
  endfunction

  function automatic void store_record(logic [DATA_W-1:0] at, logic [DATA_W-1:0] len);
    extent_start[wr_slot] = at;
    extent_len[wr_slot] = len;
    wr_slot = (wr_slot + 1) % SLOTS;
  endfunction

  // Works out the result of one request and moves the ring on accordingly.
  function automatic allocation_result_t allocate_step(logic cmd, logic [DATA_W-1:0] len);
    allocation_result_t res;
    int unsigned        n;
    int unsigned        newest;
    logic [DATA_W-1:0]  old_start;
    logic [DATA_W-1:0]  old_len;
    logic [DATA_W-1:0]  new_start;
    longint unsigned    new_end;
    longint unsigned    need;
    longint unsigned    limit64;
    logic               refused;
    res = '0;
    refused = 1'b0;
    n = held_records();
    limit64 = 64'(space_limit_q);
    if (cmd == clsa_pkg::CMD_POP) begin
      if (n != 0) begin
        res.ok = 1'b1;
        res.start_address = extent_start[rd_slot];
        res.record_length = extent_len[rd_slot];
        rd_slot = (rd_slot + 1) % SLOTS;
        ovf_flag = 1'b0;
      end
    end else begin
      res.record_length = len;
      res.ok = 1'b1;
      if (n == 0) begin
        store_record('0, len);
      end else begin
        old_start = extent_start[rd_slot];
        old_len = extent_len[rd_slot];
        if (n == 1) begin
          // A lone record is either followed directly or replaced at zero.
          need = 64'(old_len);
          need += 64'(len);
          if (need > limit64) begin
            extent_start[rd_slot] = '0;
            extent_len[rd_slot] = len;
            ovf_flag = 1'b1;
          end else begin
            res.start_address = old_start + old_len;
            store_record(res.start_address, len);
          end
        end else if (n == SLOTS - 1) begin
          refused = 1'b1;
        end else begin
          // Sums are taken at 64 bits so that they never wrap.
          newest = (wr_slot + SLOTS - 1) % SLOTS;
          new_start = extent_start[newest];
          new_end = 64'(extent_len[newest]);
          new_end += 64'(new_start);
          need = new_end + 64'(len);
          if (new_start > old_start && need <= limit64) begin
            res.start_address = new_end[DATA_W-1:0];
            store_record(res.start_address, len);
          end else if (new_start > old_start && len <= old_start) begin
            store_record('0, len);
          end else if (new_start <= old_start && need <= 64'(old_start)) begin
            res.start_address = new_end[DATA_W-1:0];
            store_record(res.start_address, len);
          end else begin
            refused = 1'b1;
          end
        end
      end
      // Out of slots or space: the oldest record goes and the push fails.
      if (refused) begin
        res.ok = 1'b0;
        rd_slot = (rd_slot + 1) % SLOTS;
        ovf_flag = 1'b1;
      end
    end
    res.overflowed = ovf_flag;
    res.record_count = COUNT_W'(held_records());
    return res;
  endfunction

  // Holds start low as long as each random draw falls below pct percent.
  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Presents one request, waits until it is taken and records its outcome.
  task automatic issue_request(logic cmd, logic [DATA_W-1:0] len, logic typed,
                               allocation_result_t typed_result);
    allocation_result_t predicted;
    start <= 1'b1;
    command <= cmd;
    request_length <= len;
    do @(posedge clk); while (busy);
    predicted = allocate_step(cmd, len);
    if (cmd == clsa_pkg::CMD_PUSH) begin
      if (predicted.ok) placed_pushes++;
      else refused_pushes++;
    end else begin
      if (predicted.ok) returned_pops++;
      else empty_pops++;
    end
    if (held_records() > peak_records) peak_records = held_records();
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The space limit is only changed once the allocator has gone quiet.
  task automatic write_space_limit(logic [DATA_W-1:0] value);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    space_limit_q = value;
    cfg_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_length(logic [DATA_W-1:0] max_len, logic wild);
    int unsigned mode;
    mode = $urandom_range(15);
    if (mode == 0) return '0;
    if (mode == 1) return max_len;
    if (wild && mode <= 3) return $urandom;
    return $urandom_range(max_len);
  endfunction

  // A run of random requests under one space limit.
  task automatic run_traffic(logic [DATA_W-1:0] limit, int items, int push_pct,
                             logic [DATA_W-1:0] max_len, logic wild);
    logic cmd;
    write_space_limit(limit);
    for (int i = 0; i < items; i++) begin
      idle_gap(rand_items < 440 ? 12 : (rand_items < 880 ? 65 : 0));
      cmd = ($urandom_range(99) < push_pct) ? clsa_pkg::CMD_PUSH : clsa_pkg::CMD_POP;
      issue_request(cmd, cmd == clsa_pkg::CMD_PUSH ? pick_length(max_len, wild) : $urandom,
                    1'b0, UNTYPED);
      rand_items++;
    end
  endtask

  task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
    end
  endtask

  // Every strobed result is held against the oldest outstanding expectation.
  always @(posedge clk) begin
    allocation_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request outstanding", results_seen);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", DATA_W'(want.ok), DATA_W'(ok));
        check_field("start_address", want.start_address, start_address);
        check_field("record_length", want.record_length, record_length);
        check_field("overflowed", DATA_W'(want.overflowed), DATA_W'(overflowed));
        check_field("record_count", DATA_W'(want.record_count), DATA_W'(record_count));
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] lim;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: edges of the fields and special cases of placement.
    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        write_space_limit(DIRECTED_ROWS[r].value);
      end else begin
        idle_gap(12);
        issue_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].value,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].expected);
      end
    end

    // Fill the ring under the widest space, then keep pushing into a full ring.
    run_traffic(32'hFFFF_FFFF, 1025, 100, 32'd65535, 1'b0);
    run_traffic(32'h0000_0000, 12, 55, 32'h0, 1'b1);
    run_traffic(32'h0000_0001, 12, 60, 32'h1, 1'b1);
    run_traffic(32'd1000, 12, 65, 32'd400, 1'b1);
    lim = $urandom;
    run_traffic(lim, 12, 60, lim / 3, 1'b1);
    run_traffic(32'hFFFF_FFFE, 12, 55, 32'h7FFF_FFFF, 1'b1);
    lim = $urandom_range(1 << 20);
    run_traffic(lim, 12, 60, lim / 4, 1'b1);

    // Let the last results come out, then allow a little slack.
    start <= 1'b0;
    for (int k = 0; k < 200 && pending_results.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Requests: %0d pushes placed, %0d refused, %0d pops returned, %0d on empty ring.",
             placed_pushes, refused_pushes, returned_pops, empty_pops);
    $display("Space limit written %0d times; ring held up to %0d records; %0d mismatches.",
             cfg_writes, peak_records, mismatches);
    if (mismatches == 0) begin
      $display("circular_log_space_allocator regression: pass");
    end else begin
      $display("circular_log_space_allocator regression: fail");
    end
    $finish;
  end

endmodule
